// ===== hw/rtl/aprs_pkg.sv =====
// Package with the shared widths, stage types and helpers of the box pair resolver.
package aprs_pkg;

    localparam int PosW  = 32;  // signed Q16.16 position
    localparam int HalfW = 30;  // unsigned Q14.16 half extent
    localparam int SumW  = 31;  // sum of two half extents
    localparam int ExtW  = 34;  // edges, center differences and moved positions
    localparam int AbsW  = 33;  // magnitude of a center difference
    localparam int OvW   = 35;  // signed overlap before the hit is known
    localparam int AmtW  = 31;  // push distance of a real collision

    typedef enum logic [1:0] {
        EV_NONE        = 2'd0,
        EV_FIRST_TRIG  = 2'd1,
        EV_SECOND_TRIG = 2'd2,
        EV_COLLISION   = 2'd3
    } event_kind_t;

    // One pair of boxes as it arrives at the ports.
    typedef struct packed {
        logic signed [PosW-1:0]  first_x;
        logic signed [PosW-1:0]  first_y;
        logic        [HalfW-1:0] first_half_w;
        logic        [HalfW-1:0] first_half_h;
        logic                    first_is_trigger;
        logic signed [PosW-1:0]  second_x;
        logic signed [PosW-1:0]  second_y;
        logic        [HalfW-1:0] second_half_w;
        logic        [HalfW-1:0] second_half_h;
        logic                    second_is_trigger;
        logic                    push_both;
    } pair_in_t;

    // Four positions and the item flags, carried unchanged down the pipe.
    typedef struct packed {
        logic signed [PosW-1:0] ax;
        logic signed [PosW-1:0] ay;
        logic signed [PosW-1:0] bx;
        logic signed [PosW-1:0] by;
        logic                   atrig;
        logic                   btrig;
        logic                   both;
    } pos_t;

    // First stage: far edges, center differences and half extent sums.
    typedef struct packed {
        pos_t                   pos;
        logic signed [ExtW-1:0] a_right;
        logic signed [ExtW-1:0] a_top;
        logic signed [ExtW-1:0] b_right;
        logic signed [ExtW-1:0] b_top;
        logic signed [ExtW-1:0] dx;
        logic signed [ExtW-1:0] dy;
        logic        [SumW-1:0] hw_sum;
        logic        [SumW-1:0] hh_sum;
    } geom_t;

    // Second stage: overlap test result and the center distance magnitudes.
    typedef struct packed {
        pos_t                   pos;
        logic                   hit;
        logic        [AbsW-1:0] adx;
        logic        [AbsW-1:0] ady;
        logic                   neg_x;
        logic                   neg_y;
        logic        [SumW-1:0] hw_sum;
        logic        [SumW-1:0] hh_sum;
    } near_t;

    function automatic logic signed [ExtW-1:0] ext_pos(input logic signed [PosW-1:0] v);
        ext_pos = ExtW'(v);
    endfunction

    function automatic logic signed [PosW-1:0] sat_pos(input logic signed [ExtW-1:0] v);
        logic signed [ExtW-1:0] max_v;
        logic signed [ExtW-1:0] min_v;
        max_v = ext_pos({1'b0, {(PosW-1){1'b1}}});
        min_v = ext_pos({1'b1, {(PosW-1){1'b0}}});
        if (v > max_v) begin
            sat_pos = max_v[PosW-1:0];
        end else if (v < min_v) begin
            sat_pos = min_v[PosW-1:0];
        end else begin
            sat_pos = v[PosW-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/aprs_geom.sv =====
// Geometry stages of the box pair resolver: edges, center differences and the overlap test.
module aprs_geom (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  aprs_pkg::pair_in_t in_pair,
    output logic              out_valid,
    output aprs_pkg::near_t   out_near
);

    logic            s1_valid_reg;
    aprs_pkg::geom_t s1_reg;
    aprs_pkg::geom_t s1_next;
    logic            s2_valid_reg;
    aprs_pkg::near_t s2_reg;
    aprs_pkg::near_t s2_next;

    always_comb
    begin
        logic signed [aprs_pkg::ExtW-1:0] ahw_e;
        logic signed [aprs_pkg::ExtW-1:0] ahh_e;
        logic signed [aprs_pkg::ExtW-1:0] bhw_e;
        logic signed [aprs_pkg::ExtW-1:0] bhh_e;
        ahw_e = aprs_pkg::ExtW'(signed'({1'b0, in_pair.first_half_w}));
        ahh_e = aprs_pkg::ExtW'(signed'({1'b0, in_pair.first_half_h}));
        bhw_e = aprs_pkg::ExtW'(signed'({1'b0, in_pair.second_half_w}));
        bhh_e = aprs_pkg::ExtW'(signed'({1'b0, in_pair.second_half_h}));

        s1_next.pos.ax    = in_pair.first_x;
        s1_next.pos.ay    = in_pair.first_y;
        s1_next.pos.bx    = in_pair.second_x;
        s1_next.pos.by    = in_pair.second_y;
        s1_next.pos.atrig = in_pair.first_is_trigger;
        s1_next.pos.btrig = in_pair.second_is_trigger;
        s1_next.pos.both  = in_pair.push_both;

        s1_next.a_right = aprs_pkg::ext_pos(in_pair.first_x) + (ahw_e <<< 1);
        s1_next.a_top   = aprs_pkg::ext_pos(in_pair.first_y) + (ahh_e <<< 1);
        s1_next.b_right = aprs_pkg::ext_pos(in_pair.second_x) + (bhw_e <<< 1);
        s1_next.b_top   = aprs_pkg::ext_pos(in_pair.second_y) + (bhh_e <<< 1);

        // Center difference: (a + a_half) - (b + b_half).
        s1_next.dx = aprs_pkg::ext_pos(in_pair.first_x) - aprs_pkg::ext_pos(in_pair.second_x)
                     + ahw_e - bhw_e;
        s1_next.dy = aprs_pkg::ext_pos(in_pair.first_y) - aprs_pkg::ext_pos(in_pair.second_y)
                     + ahh_e - bhh_e;

        s1_next.hw_sum = {1'b0, in_pair.first_half_w} + {1'b0, in_pair.second_half_w};
        s1_next.hh_sum = {1'b0, in_pair.first_half_h} + {1'b0, in_pair.second_half_h};
    end

    always_comb
    begin
        logic signed [aprs_pkg::ExtW-1:0] ax_e;
        logic signed [aprs_pkg::ExtW-1:0] ay_e;
        logic signed [aprs_pkg::ExtW-1:0] bx_e;
        logic signed [aprs_pkg::ExtW-1:0] by_e;
        logic signed [aprs_pkg::ExtW-1:0] adx_full;
        logic signed [aprs_pkg::ExtW-1:0] ady_full;
        ax_e = aprs_pkg::ext_pos(s1_reg.pos.ax);
        ay_e = aprs_pkg::ext_pos(s1_reg.pos.ay);
        bx_e = aprs_pkg::ext_pos(s1_reg.pos.bx);
        by_e = aprs_pkg::ext_pos(s1_reg.pos.by);
        adx_full = s1_reg.dx[aprs_pkg::ExtW-1] ? -s1_reg.dx : s1_reg.dx;
        ady_full = s1_reg.dy[aprs_pkg::ExtW-1] ? -s1_reg.dy : s1_reg.dy;

        s2_next.pos = s1_reg.pos;
        // Touching edges do not count as overlap.
        s2_next.hit = (ax_e < s1_reg.b_right) && (s1_reg.a_right > bx_e) &&
                      (ay_e < s1_reg.b_top) && (s1_reg.a_top > by_e);
        s2_next.adx    = adx_full[aprs_pkg::AbsW-1:0];
        s2_next.ady    = ady_full[aprs_pkg::AbsW-1:0];
        s2_next.neg_x  = s1_reg.dx[aprs_pkg::ExtW-1];
        s2_next.neg_y  = s1_reg.dy[aprs_pkg::ExtW-1];
        s2_next.hw_sum = s1_reg.hw_sum;
        s2_next.hh_sum = s1_reg.hh_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_near  = s2_reg;

endmodule

// ===== hw/rtl/aprs_push.sv =====
// Resolution stages of the box pair resolver: overlaps, axis choice, push and saturation.
module aprs_push (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  aprs_pkg::near_t                   in_near,
    output logic                              out_valid,
    output logic signed [aprs_pkg::PosW-1:0]  out_first_x,
    output logic signed [aprs_pkg::PosW-1:0]  out_first_y,
    output logic signed [aprs_pkg::PosW-1:0]  out_second_x,
    output logic signed [aprs_pkg::PosW-1:0]  out_second_y,
    output aprs_pkg::event_kind_t             out_kind
);

    // Stage three: overlap per axis and the event kind.
    logic                            s3_valid_reg;
    aprs_pkg::pos_t                  s3_pos_reg;
    logic signed [aprs_pkg::OvW-1:0] s3_ovx_reg;
    logic signed [aprs_pkg::OvW-1:0] s3_ovy_reg;
    logic                            s3_neg_x_reg;
    logic                            s3_neg_y_reg;
    aprs_pkg::event_kind_t           s3_kind_reg;
    logic signed [aprs_pkg::OvW-1:0] s3_ovx_next;
    logic signed [aprs_pkg::OvW-1:0] s3_ovy_next;
    aprs_pkg::event_kind_t           s3_kind_next;

    // Stage four: chosen axis, direction and push distance.
    logic                             s4_valid_reg;
    aprs_pkg::pos_t                   s4_pos_reg;
    aprs_pkg::event_kind_t            s4_kind_reg;
    logic                             s4_use_x_reg;
    logic                             s4_neg_reg;
    logic [aprs_pkg::AmtW-1:0]        s4_amt_reg;
    logic                             s4_use_x_next;
    logic                             s4_neg_next;
    logic [aprs_pkg::AmtW-1:0]        s4_amt_next;

    // Stage five: saturated results.
    logic                             s5_valid_reg;
    logic signed [aprs_pkg::PosW-1:0] s5_ax_reg;
    logic signed [aprs_pkg::PosW-1:0] s5_ay_reg;
    logic signed [aprs_pkg::PosW-1:0] s5_bx_reg;
    logic signed [aprs_pkg::PosW-1:0] s5_by_reg;
    aprs_pkg::event_kind_t            s5_kind_reg;
    logic signed [aprs_pkg::PosW-1:0] s5_ax_next;
    logic signed [aprs_pkg::PosW-1:0] s5_ay_next;
    logic signed [aprs_pkg::PosW-1:0] s5_bx_next;
    logic signed [aprs_pkg::PosW-1:0] s5_by_next;

    always_comb
    begin
        s3_ovx_next = aprs_pkg::OvW'(signed'({1'b0, in_near.hw_sum}))
                      - aprs_pkg::OvW'(signed'({1'b0, in_near.adx}));
        s3_ovy_next = aprs_pkg::OvW'(signed'({1'b0, in_near.hh_sum}))
                      - aprs_pkg::OvW'(signed'({1'b0, in_near.ady}));
        if (!in_near.hit) begin
            s3_kind_next = aprs_pkg::EV_NONE;
        end else if (in_near.pos.atrig) begin
            s3_kind_next = aprs_pkg::EV_FIRST_TRIG;
        end else if (in_near.pos.btrig) begin
            s3_kind_next = aprs_pkg::EV_SECOND_TRIG;
        end else begin
            s3_kind_next = aprs_pkg::EV_COLLISION;
        end
    end

    always_comb
    begin
        logic signed [aprs_pkg::OvW-1:0] ov;
        // Ties go to the y axis.
        s4_use_x_next = s3_ovx_reg < s3_ovy_reg;
        ov            = s4_use_x_next ? s3_ovx_reg : s3_ovy_reg;
        s4_neg_next   = s4_use_x_next ? s3_neg_x_reg : s3_neg_y_reg;
        // On a real collision the overlap lies in (0, 2^31), so the low bits carry it.
        s4_amt_next   = s3_pos_reg.both ? ov[aprs_pkg::AmtW:1] : ov[aprs_pkg::AmtW-1:0];
    end

    always_comb
    begin
        logic signed [aprs_pkg::ExtW-1:0] amt_e;
        logic signed [aprs_pkg::ExtW-1:0] a_coord;
        logic signed [aprs_pkg::ExtW-1:0] b_coord;
        logic signed [aprs_pkg::ExtW-1:0] a_moved;
        logic signed [aprs_pkg::ExtW-1:0] b_moved;
        amt_e   = aprs_pkg::ExtW'(signed'({1'b0, s4_amt_reg}));
        a_coord = aprs_pkg::ext_pos(s4_use_x_reg ? s4_pos_reg.ax : s4_pos_reg.ay);
        b_coord = aprs_pkg::ext_pos(s4_use_x_reg ? s4_pos_reg.bx : s4_pos_reg.by);
        // The first box moves away from the second; the second moves the other way.
        a_moved = s4_neg_reg ? a_coord - amt_e : a_coord + amt_e;
        b_moved = s4_neg_reg ? b_coord + amt_e : b_coord - amt_e;

        s5_ax_next = s4_pos_reg.ax;
        s5_ay_next = s4_pos_reg.ay;
        s5_bx_next = s4_pos_reg.bx;
        s5_by_next = s4_pos_reg.by;
        if (s4_kind_reg == aprs_pkg::EV_COLLISION)
        begin
            if (s4_use_x_reg)
            begin
                s5_ax_next = aprs_pkg::sat_pos(a_moved);
                if (s4_pos_reg.both)
                begin
                    s5_bx_next = aprs_pkg::sat_pos(b_moved);
                end
            end
            else
            begin
                s5_ay_next = aprs_pkg::sat_pos(a_moved);
                if (s4_pos_reg.both)
                begin
                    s5_by_next = aprs_pkg::sat_pos(b_moved);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_pos_reg   <= in_near.pos;
        s3_ovx_reg   <= s3_ovx_next;
        s3_ovy_reg   <= s3_ovy_next;
        s3_neg_x_reg <= in_near.neg_x;
        s3_neg_y_reg <= in_near.neg_y;
        s3_kind_reg  <= s3_kind_next;

        s4_pos_reg   <= s3_pos_reg;
        s4_kind_reg  <= s3_kind_reg;
        s4_use_x_reg <= s4_use_x_next;
        s4_neg_reg   <= s4_neg_next;
        s4_amt_reg   <= s4_amt_next;

        s5_ax_reg    <= s5_ax_next;
        s5_ay_reg    <= s5_ay_next;
        s5_bx_reg    <= s5_bx_next;
        s5_by_reg    <= s5_by_next;
        s5_kind_reg  <= s4_kind_reg;
    end

    assign out_valid    = s5_valid_reg;
    assign out_first_x  = s5_ax_reg;
    assign out_first_y  = s5_ay_reg;
    assign out_second_x = s5_bx_reg;
    assign out_second_y = s5_by_reg;
    assign out_kind     = s5_kind_reg;

endmodule

// ===== hw/rtl/aabb_pair_overlap_resolve_unit.sv =====
// Top level of the box pair overlap resolver.
//
// The unit takes one pair of axis-aligned boxes per clock cycle and resolves
// their overlap. It is a five stage pipeline: an item accepted with start high
// comes out of the last stage as a one cycle pulse on done, together with the
// four resolved positions and event_kind. busy is always low, so a new item can
// be given in every cycle, and results appear in the order the items went in,
// one per item. The receiver cannot stall the unit: it must capture each result
// in the cycle in which done is high. The stages are: edges and center
// differences, overlap test and magnitudes, per axis overlap, axis choice with
// push distance, and the saturating move.
//
// Positions are signed Q16.16 and half extents unsigned Q14.16. Boxes that only
// touch do not overlap. A trigger box reports an event (first box ahead of the
// second) and moves nothing. A collision pushes along the axis of smaller
// overlap, the y axis on a tie: either the first box alone by the full overlap,
// or both boxes by half of it (rounded down) in opposite directions. A zero
// center difference pushes the first box toward positive coordinates. Moved
// positions saturate to the signed 32-bit range.
module aabb_pair_overlap_resolve_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [aprs_pkg::PosW-1:0]  first_x,
    input  logic signed [aprs_pkg::PosW-1:0]  first_y,
    input  logic        [aprs_pkg::HalfW-1:0] first_half_w,
    input  logic        [aprs_pkg::HalfW-1:0] first_half_h,
    input  logic                              first_is_trigger,
    input  logic signed [aprs_pkg::PosW-1:0]  second_x,
    input  logic signed [aprs_pkg::PosW-1:0]  second_y,
    input  logic        [aprs_pkg::HalfW-1:0] second_half_w,
    input  logic        [aprs_pkg::HalfW-1:0] second_half_h,
    input  logic                              second_is_trigger,
    input  logic                              push_both,
    output logic                              done,
    output logic signed [aprs_pkg::PosW-1:0]  new_first_x,
    output logic signed [aprs_pkg::PosW-1:0]  new_first_y,
    output logic signed [aprs_pkg::PosW-1:0]  new_second_x,
    output logic signed [aprs_pkg::PosW-1:0]  new_second_y,
    output logic        [1:0]                 event_kind
);

    aprs_pkg::pair_in_t    pair;
    logic                  accept;
    logic                  near_valid;
    aprs_pkg::near_t       near;
    aprs_pkg::event_kind_t kind;

    // Every stage moves on each cycle, so the unit never refuses an item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pair.first_x           = first_x;
    assign pair.first_y           = first_y;
    assign pair.first_half_w      = first_half_w;
    assign pair.first_half_h      = first_half_h;
    assign pair.first_is_trigger  = first_is_trigger;
    assign pair.second_x          = second_x;
    assign pair.second_y          = second_y;
    assign pair.second_half_w     = second_half_w;
    assign pair.second_half_h     = second_half_h;
    assign pair.second_is_trigger = second_is_trigger;
    assign pair.push_both         = push_both;

    // Stages one and two: geometry and the strict overlap test.
    aprs_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_pair   (pair),
        .out_valid (near_valid),
        .out_near  (near)
    );

    // Stages three to five: event kind, axis choice, push and saturation.
    aprs_push u_push (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (near_valid),
        .in_near      (near),
        .out_valid    (done),
        .out_first_x  (new_first_x),
        .out_first_y  (new_first_y),
        .out_second_x (new_second_x),
        .out_second_y (new_second_y),
        .out_kind     (kind)
    );

    assign event_kind = kind;

endmodule
